// ----- src/timed_sample_history_fifo_assert.svh -----
// assertion macros used by the history fifo rtl
`ifndef TIMED_SAMPLE_HISTORY_FIFO_ASSERT_SVH
`define TIMED_SAMPLE_HISTORY_FIFO_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSHF_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define TSHF_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) else $error(msg);

`endif

// ----- src/tshf_pkg.sv -----
`default_nettype none

package tshf_pkg;

  // field widths fixed by the stream format
  localparam int TIME_W     = 48;
  localparam int POS_W      = 16;
  localparam int DT_W       = 24;
  localparam int MINI_W     = 24;
  localparam int MAXR_W     = 32;
  localparam int MAXF_W     = 7;
  localparam int IDX_W      = 6;
  localparam int CNT_OUT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 104;

  // cells folded into one register of the read gather tree
  localparam int GRP = 8;

  // register reset values
  localparam logic [MINI_W-1:0] MIN_INTERVAL_RST = '0;
  localparam logic [MAXR_W-1:0] MAX_RECORD_RST   = 32'd1000000;
  localparam logic [MAXF_W-1:0] MAX_FRAMES_RST   = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOCK,
    ST_AGE,
    ST_LIMIT,
    ST_PUSH,
    ST_READ,
    ST_GATHER,
    ST_DONE
  } state_t;

  typedef enum logic {
    FUNC_UPDATE = 1'b0,
    FUNC_READ   = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL = 2'd0,
    REG_MAX_RECORD   = 2'd1,
    REG_MAX_FRAMES   = 2'd2
  } cfg_reg_t;

  // one stored sample, x in the low bits
  typedef struct packed {
    logic [TIME_W-1:0]       stamp;
    logic                    blink;
    logic                    tele;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } sample_t;

  // input tdata layout, x in the low bits
  typedef struct packed {
    logic                    pad;
    logic [IDX_W-1:0]        index;
    logic                    teleport;
    logic [DT_W-1:0]         delta_time;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } in_payload_t;

  // per-cycle command broadcast to the cell row
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/tshf_cell.sv -----
`default_nettype none

module tshf_cell
  import tshf_pkg::*;
#(
  parameter int AW = 6,
  parameter logic [AW-1:0] POS = '0
) (
  input  logic          clk,
  input  cell_ctrl_t    ctrl,
  input  logic [AW-1:0] wr_pos,
  input  logic [AW-1:0] rd_pos,
  input  sample_t       wdata,
  input  sample_t       nxt,
  output sample_t       data,
  output sample_t       rd_data
);

  // shift toward the head, or take the new sample at the tail slot
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= nxt;
    end else if (ctrl.load && (wr_pos == POS)) begin
      data <= wdata;
    end
  end

  // drive the read bus only when selected
  assign rd_data = (rd_pos == POS) ? data : '0;

endmodule

`default_nettype wire

// ----- src/timed_sample_history_fifo.sv -----
`default_nettype none

// channel   dir   handshake                 payload
// s_*       in    s_tvalid / s_tready       s_tdata, s_tuser (func)
// m_*       out   m_tvalid / m_tready       m_tdata
// cfg_*     in    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// an update walks clock, age, limit, push and done (age and limit pops shift
// the whole cell row by one entry each); zero step skips to done, read via gather
// reads gather through one registered or-tree level over the cell row
// reset clears count, clock, blink and config; sample cells hold no reset
// a finished result sits in the output register; the next item is accepted
// meanwhile and only its result waits for m_tready

module timed_sample_history_fifo
  import tshf_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x, pos_y, delta_time, teleport, index, pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // count, pushed, evicted, entry_valid, entry_x, entry_y,
  // entry_teleport, entry_blink, entry_time, pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "timed_sample_history_fifo_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > MAXF_W) ? CW : MAXF_W;
  localparam int NG = (DEPTH + GRP - 1) / GRP;

  // configuration
  logic [MINI_W-1:0] min_interval;
  logic [MAXR_W-1:0] max_record;
  logic [MAXF_W-1:0] max_frames;

  // control and bookkeeping
  state_t            state, state_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     evicted;
  logic              pushed;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] last_time;
  logic              blink;

  // captured item
  logic              func_q;
  logic [POS_W-1:0]  px_q;
  logic [POS_W-1:0]  py_q;
  logic [DT_W-1:0]   dt_q;
  logic              tele_q;
  logic [IDX_W-1:0]  idx_q;

  // result
  logic              ent_valid;
  sample_t           ent;

  in_payload_t       in_p;
  cell_ctrl_t        cctrl;
  logic              out_load;
  logic              in_accept;

  sample_t           cell_data [DEPTH];
  sample_t           cell_rd   [DEPTH];
  sample_t           grp_d     [NG];
  sample_t           grp_q     [NG];
  sample_t           gathered;
  sample_t           wdata;

  logic [TIME_W:0]   now_sum;
  logic [TIME_W-1:0] now_sat;
  logic              age_hit;
  logic [LW-1:0]     lim;
  logic [LW-1:0]     mf_ext;
  logic              over_lim;
  logic              do_push;

  assign in_p      = in_payload_t'(s_tdata);
  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;

  // saturating clock advance
  assign now_sum = {1'b0, now} + (TIME_W+1)'(dt_q);
  assign now_sat = now_sum[TIME_W] ? '1 : now_sum[TIME_W-1:0];

  // head sample older than the window
  assign age_hit = (count != '0) &&
                   (({1'b0, cell_data[0].stamp} + (TIME_W+1)'(max_record)) <
                    {1'b0, now});

  // frame limit clamped to one .. DEPTH
  assign mf_ext = LW'(max_frames);
  always_comb begin
    if (max_frames == '0) begin
      lim = LW'(1);
    end else if (mf_ext > LW'(DEPTH)) begin
      lim = LW'(DEPTH);
    end else begin
      lim = mf_ext;
    end
  end
  assign over_lim = LW'(count) >= lim;

  // store decision
  assign do_push = (count == '0) || tele_q ||
                   ({1'b0, now} >= ({1'b0, last_time} + (TIME_W+1)'(min_interval)));

  assign wdata = '{stamp: now, blink: ~blink, tele: tele_q, y: py_q, x: px_q};

  // cell row, head at cell zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sample_t nxt_i;
    if (i == DEPTH - 1) begin : g_tail
      assign nxt_i = '0;
    end else begin : g_link
      assign nxt_i = cell_data[i+1];
    end
    tshf_cell #(
      .AW  (AW),
      .POS (AW'(i))
    ) u_cell (
      .clk     (clk),
      .ctrl    (cctrl),
      .wr_pos  (AW'(count)),
      .rd_pos  (AW'(idx_q)),
      .wdata   (wdata),
      .nxt     (nxt_i),
      .data    (cell_data[i]),
      .rd_data (cell_rd[i])
    );
  end

  // first gather level: or over groups of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          grp_d[g] = grp_d[g] | cell_rd[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_q <= grp_d;
  end

  // second gather level
  always_comb begin
    gathered = '0;
    for (int g = 0; g < NG; g++) begin
      gathered = gathered | grp_q[g];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser[0] == FUNC_READ) begin
            state_next = ST_READ;
          end else if (in_p.delta_time == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_CLOCK;
          end
        end
      end
      ST_CLOCK:  state_next = ST_AGE;
      ST_AGE: begin
        if (!age_hit) begin
          state_next = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (!over_lim) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH:   state_next = ST_DONE;
      ST_READ:   state_next = ST_GATHER;
      ST_GATHER: state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready    = 1'b0;
    cctrl.shift = 1'b0;
    cctrl.load  = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_IDLE:  s_tready = 1'b1;
      ST_AGE:   cctrl.shift = age_hit;
      ST_LIMIT: cctrl.shift = over_lim;
      ST_PUSH:  cctrl.load = do_push;
      ST_DONE:  out_load = !m_tvalid || m_tready;
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
      max_record   <= MAX_RECORD_RST;
      max_frames   <= MAX_FRAMES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_INTERVAL: min_interval <= cfg_data[MINI_W-1:0];
        REG_MAX_RECORD:   max_record   <= cfg_data[MAXR_W-1:0];
        REG_MAX_FRAMES:   max_frames   <= cfg_data[MAXF_W-1:0];
        default: begin
          max_frames <= max_frames;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_q <= s_tuser[0];
      px_q   <= in_p.pos_x;
      py_q   <= in_p.pos_y;
      dt_q   <= in_p.delta_time;
      tele_q <= in_p.teleport;
      idx_q  <= in_p.index;
    end
  end

  // fifo bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      now   <= '0;
      blink <= 1'b0;
    end else begin
      if (state == ST_CLOCK) begin
        now <= now_sat;
      end
      if (cctrl.shift) begin
        count <= count - CW'(1);
      end else if (cctrl.load) begin
        count <= count + CW'(1);
        blink <= ~blink;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cctrl.load) begin
      last_time <= now;
    end
  end

  // per-item result fields
  always_ff @(posedge clk) begin
    if (in_accept) begin
      evicted   <= '0;
      pushed    <= 1'b0;
      ent_valid <= 1'b0;
      ent       <= '0;
    end else begin
      if (cctrl.shift) begin
        evicted <= evicted + CW'(1);
      end
      if (cctrl.load) begin
        pushed <= 1'b1;
      end
      if (state == ST_READ && func_q == FUNC_READ) begin
        ent_valid <= LW'(idx_q) < LW'(count);
      end
      if (state == ST_GATHER) begin
        ent <= ent_valid ? gathered : '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, ent, ent_valid, CNT_OUT_W'(evicted), pushed,
                  CNT_OUT_W'(count)};
    end
  end

  // checks
  `TSHF_ASSERT_IMP(a_count_bound, 1'b1, LW'(count) <= LW'(DEPTH), "count above depth")
  `TSHF_ASSERT_IMP(a_shift_nonempty, cctrl.shift, count != '0, "pop from empty row")
  `TSHF_ASSERT_NXT(a_push_count, cctrl.load, count == $past(count) + CW'(1), "push lost")
  `TSHF_ASSERT_NXT(a_clock_monotonic, !rst, now >= $past(now), "clock went back")

endmodule

`default_nettype wire
